// ----- hw/rtl/integer_to_text_any_base_macros.svh -----
// assertion macros for the integer to text converter
// used by the top level only, no other dependencies
`ifndef INTEGER_TO_TEXT_ANY_BASE_MACROS_SVH
`define INTEGER_TO_TEXT_ANY_BASE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ITAB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ITAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/itab_pkg.sv -----
// shared constants, types and helpers for the integer to text converter
// no dependencies
`default_nettype none

package itab_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int RADIX_W        = 6;
    localparam int DIGIT_W        = 6;
    localparam int CHAR_W         = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET  = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN    = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX    = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] DECIMAL_BASE = RADIX_W'(10);

    localparam logic [CHAR_W-1:0]  DIGIT_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0]  LETTER_A     = 7'h61;
    localparam logic [CHAR_W-1:0]  MINUS_SIGN   = 7'h2d;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN    = DIGIT_W'(10);

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } itab_div_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DIGIT_TEN)
            c = LETTER_A + CHAR_W'(d - DIGIT_TEN);
        else
            c = DIGIT_ZERO + CHAR_W'(d);
        return c;
    endfunction

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] e;
        if (r < RADIX_MIN)
            e = RADIX_MIN;
        else if (r > RADIX_MAX)
            e = RADIX_MAX;
        else
            e = r;
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/itab_divider.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on itab_pkg
`default_nettype none

module itab_divider
    import itab_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [RADIX_W-1:0]    divisor,
    output logic      [VALUE_BITS-1:0] quotient,
    output logic      [DIGIT_W-1:0]    remainder,
    output itab_div_status_t           status
);

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [VALUE_BITS-1:0] quo_reg;
    logic [VALUE_BITS-1:0] quo_next;
    logic [DIGIT_W-1:0]    rem_reg;
    logic [DIGIT_W-1:0]    rem_next;
    logic [RADIX_W-1:0]    div_reg;
    logic [DIGIT_W:0]      trial;
    logic [DIGIT_W:0]      diff;
    logic                  fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[VALUE_BITS-1]};
        fits     = trial >= {1'b0, div_reg};
        diff     = trial - {1'b0, div_reg};
        rem_next = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        quo_next = {quo_reg[VALUE_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(VALUE_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/itab_digit_stack.sv -----
// digit store, least significant digit written first, read back in reverse
// depends on itab_pkg
`default_nettype none

module itab_digit_stack
    import itab_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(VALUE_BITS)-1:0] wr_addr,
    input  wire logic [DIGIT_W-1:0]            wr_data,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(VALUE_BITS)-1:0] rd_addr,
    output logic      [DIGIT_W-1:0]            rd_data
);

    logic [DIGIT_W-1:0] mem [VALUE_BITS];
    logic [DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/integer_to_text_any_base.sv -----
// Integer to ASCII text converter in a configurable base from 2 to 36. One request carries
// a VALUE_BITS-bit pattern; the block returns one character per response, most significant
// first, with last set on the final one. Digits above nine are lower-case letters, zero
// gives "0", and in base ten a set sign bit gives '-' and the magnitude; other bases read
// the pattern as unsigned. Radix values below 2 act as 2 and above 36 act as 36. Digits
// come from a shared restoring divider that yields one quotient bit per cycle, and each
// remainder is stored in the digit store; each digit character is then read back from
// the store, turned into ASCII and presented, while a minus sign is presented directly,
// and the sink may hold off each character by keeping out_ready low until it is taken.
// in_ready is high only while nothing is in flight; radix_write may be used only then.
// depends on itab_pkg, itab_divider, itab_digit_stack and the macros header
`default_nettype none

`include "integer_to_text_any_base_macros.svh"

module integer_to_text_any_base
    import itab_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  radix_write,
    input  wire logic [RADIX_W-1:0]    radix,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [CHAR_W-1:0]     character,
    output logic                       last
);

    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int AW = $clog2(VALUE_BITS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_FETCH = 5'b00100,
        S_LOAD  = 5'b01000,
        S_SHOW  = 5'b10000
    } itab_state_t;

    itab_state_t           state_reg, state_next;
    logic [RADIX_W-1:0]    radix_reg;
    logic [RADIX_W-1:0]    eff_radix;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         top_idx;
    logic                  neg_reg, neg_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  is_neg;
    logic [VALUE_BITS-1:0] start_dividend;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_W-1:0]    remainder;
    itab_div_status_t      div_status;

    logic                  wr_en;
    logic                  rd_en;
    logic [DIGIT_W-1:0]    rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (radix_write)
            radix_reg <= radix;
    end

    always_comb
    begin
        eff_radix      = clamp_radix(radix_reg);
        is_neg         = (eff_radix == DECIMAL_BASE) && value[VALUE_BITS-1];
        start_dividend = is_neg ? (~value + VALUE_BITS'(1)) : value;
        top_idx        = count_reg - CW'(1);
    end

    itab_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (eff_radix),
        .quotient  (quotient),
        .remainder (remainder),
        .status    (div_status)
    );

    itab_digit_stack #(
        .VALUE_BITS (VALUE_BITS)
    ) u_digit_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (remainder),
        .rd_en   (rd_en),
        .rd_addr (top_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        neg_next     = neg_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        div_start    = 1'b0;
        div_dividend = quotient;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    div_start    = 1'b1;
                    div_dividend = start_dividend;
                    neg_next     = is_neg;
                    count_next   = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (quotient == '0)
                        state_next = S_FETCH;
                    else
                        div_start = 1'b1;
                end
            end
            S_FETCH:
            begin
                if (neg_reg)
                begin
                    char_next  = MINUS_SIGN;
                    last_next  = 1'b0;
                    neg_next   = 1'b0;
                    state_next = S_SHOW;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                char_next  = digit_char(rd_data);
                last_next  = (count_reg == CW'(1));
                count_next = top_idx;
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (out_ready)
                    state_next = last_reg ? S_IDLE : S_FETCH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_SHOW);
    assign character = char_reg;
    assign last      = last_reg;

    `ITAB_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input taken while a response is pending")
    `ITAB_ASSERT_NEXT(a_final_frees, out_valid && out_ready && last, in_ready, "busy after last")
    `ITAB_ASSERT_NOW(a_sign_not_last, out_valid && character == MINUS_SIGN, !last, "sign is last")
    `ITAB_ASSERT_NOW(a_stack_bound, 1'b1, count_reg <= CW'(VALUE_BITS), "digit store overflow")
    `ITAB_ASSERT_NOW(a_div_in_loop, div_status.busy, state_reg == S_DIV, "stray divider")

endmodule

`default_nettype wire

// ----- sim/tb_integer_to_text_any_base.sv -----
// testbench for integer_to_text_any_base: sends integers, predicts the text in the current base
// and checks every character and its last mark in order
// depends on itab_pkg and the integer_to_text_any_base rtl
`timescale 1ns / 1ps

module tb_integer_to_text_any_base;
    import itab_pkg::*;

    localparam int VB            = VALUE_BITS_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 2500;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              final_char;
    } text_char_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              radix_write;
    logic [RADIX_W-1:0] radix;
    logic              in_valid;
    logic              in_ready;
    logic [VB-1:0]     value;
    logic              out_valid;
    logic              out_ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    text_char_t        expected_text[$];
    logic [RADIX_W-1:0] radix_setting;
    bit                no_gaps = 1'b0;
    int                sink_hold_cycles = 0;
    int                mismatches = 0;
    int                requests_sent = 0;
    int                chars_checked = 0;
    int                radix_writes = 0;

    integer_to_text_any_base #(
        .VALUE_BITS (VB)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_write (radix_write),
        .radix       (radix),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .character   (character),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #100_000_000;
        $display("timeout with %0d characters still expected", expected_text.size());
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [VB-1:0] random_value();
        logic [VB-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6:          v = $urandom_range(0, 1500);
            7:             v = -VB'($urandom_range(1, 1500));
            8:             v = {VB{1'b1}} >> $urandom_range(0, VB - 1);
            default:       v = VB'(1) << $urandom_range(0, VB - 1);
        endcase
        return v;
    endfunction

    // expected characters for one integer in the current base
    task automatic queue_rendering(input logic [VB-1:0] v);
        logic [VB-1:0]     magnitude;
        logic [VB-1:0]     base;
        logic [VB-1:0]     digit;
        logic [CHAR_W-1:0] text[$];
        logic              negative;
        text_char_t        entry;
        if (radix_setting < RADIX_MIN)
            base = VB'(RADIX_MIN);
        else if (radix_setting > RADIX_MAX)
            base = VB'(RADIX_MAX);
        else
            base = VB'(radix_setting);
        negative  = (base == VB'(DECIMAL_BASE)) && v[VB-1];
        magnitude = negative ? -v : v;
        do
        begin
            digit = magnitude % base;
            if (digit >= VB'(DIGIT_TEN))
                text.push_front(LETTER_A + CHAR_W'(digit - VB'(DIGIT_TEN)));
            else
                text.push_front(DIGIT_ZERO + CHAR_W'(digit));
            magnitude = magnitude / base;
        end
        while (magnitude != 0);
        if (negative)
            text.push_front(MINUS_SIGN);
        foreach (text[k])
        begin
            entry.code       = text[k];
            entry.final_char = (k == text.size() - 1);
            expected_text.push_back(entry);
        end
    endtask

    task automatic send_value(input logic [VB-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        queue_rendering(v);
        requests_sent++;
    endtask

    task automatic wait_drained();
        int n;
        in_valid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && expected_text.size() != 0; n++)
            @(posedge clk);
        if (expected_text.size() != 0)
        begin
            report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
            expected_text.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        wait_drained();
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        radix_write <= 1'b1;
        radix       <= r;
        @(posedge clk);
        radix_write <= 1'b0;
        radix_setting = r;
        radix_writes++;
    endtask

    // reset base is ten
    task automatic test_decimal_extremes();
        logic [VB-1:0] cases [9] = '{32'd0, 32'd1, 32'd9, 32'd10, 32'hffff_ffff,
                                     32'h8000_0000, 32'h7fff_ffff, 32'd12345, -32'd12345};
        foreach (cases[k])
            send_value(cases[k]);
    endtask

    task automatic test_radix_extremes();
        write_radix(RADIX_MIN);
        send_value(32'd0);
        send_value(32'hffff_ffff);
        send_value(32'h8000_0000);
        write_radix(RADIX_W'(0));
        send_value(32'd5);
        write_radix(RADIX_W'(1));
        send_value(32'hffff_fffe);
        write_radix(RADIX_MAX);
        send_value(32'd35);
        send_value(32'd36);
        send_value(32'hffff_ffff);
        write_radix(RADIX_W'(37));
        send_value(32'd1295);
        write_radix(RADIX_W'(63));
        send_value(32'h8000_0000);
        write_radix(RADIX_W'(16));
        send_value(32'hdead_beef);
        // sign bit set outside base ten reads as unsigned
        write_radix(RADIX_W'(11));
        send_value(32'hffff_fff6);
    endtask

    task automatic test_random_values();
        logic [RADIX_W-1:0] r;
        for (int phase = 0; phase < 16; phase++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: r = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
                7:                   r = DECIMAL_BASE;
                8:                   r = RADIX_W'(16);
                default:             r = RADIX_W'($urandom_range(0, 63));
            endcase
            write_radix(r);
            no_gaps = (phase % 4 == 3);
            repeat (26) send_value(random_value());
            no_gaps = 1'b0;
        end
    endtask

    // sink holds off while requests keep coming, so the input stalls
    task automatic test_input_backpressure();
        write_radix(DECIMAL_BASE);
        no_gaps = 1'b1;
        sink_hold_cycles = HOLD_CYCLES;
        repeat (8) send_value(random_value());
        no_gaps = 1'b0;
        wait_drained();
    endtask

    task automatic test_sender_pause();
        repeat (10) send_value(random_value());
        wait_drained();
        no_gaps = 1'b1;
        repeat (10) send_value(random_value());
        no_gaps = 1'b0;
    endtask

    // sink pacing
    initial
    begin
        int hold;
        int stall;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                hold = sink_hold_cycles;
                sink_hold_cycles = 0;
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall == 0)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    repeat (stall - 1) @(posedge clk);
                end
            end
        end
    end

    // sampled on the falling edge, ahead of the accepting rising edge
    always @(negedge clk)
    begin : text_checker
        text_char_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_text.size() == 0)
                report_mismatch($sformatf("unexpected character 0x%0h last %0b", character, last));
            else
            begin
                want = expected_text.pop_front();
                chars_checked++;
                if (character !== want.code)
                    report_mismatch($sformatf("character 0x%0h, expected 0x%0h",
                                              character, want.code));
                if (last !== want.final_char)
                    report_mismatch($sformatf("last %0b, expected %0b on character 0x%0h",
                                              last, want.final_char, want.code));
            end
        end
    end

    initial
    begin
        in_valid    <= 1'b0;
        value       <= '0;
        radix_write <= 1'b0;
        radix       <= RADIX_RESET;
        rst_n       <= 1'b0;
        radix_setting = RADIX_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_decimal_extremes();
        test_radix_extremes();
        test_random_values();
        test_input_backpressure();
        test_sender_pause();
        wait_drained();
        $display("converted %0d integers into %0d checked characters over %0d base settings,",
                 requests_sent, chars_checked, radix_writes);
        $display("with out-of-range bases, a long output hold and a drained pause");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
